### rtl/asw_pkg.sv
package asw_pkg;

	localparam int MAX_WINDOW    = 8;
	localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
	localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
	localparam int SEQ_BITS      = 16;
	localparam int TIMER_BITS    = 16;
	localparam int MISS_BITS     = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_RETX = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] ack_number;
		logic        ack_valid;
	} item_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [15:0] seq_number;
		logic        accepted;
		logic [15:0] window_base;
		logic [3:0]  in_flight;
		logic [31:0] miss_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        arq_mode;
		logic [3:0]  window_size;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic                  we;
		logic [SLOT_BITS-1:0]  wr_addr;
		logic [TIMER_BITS-1:0] wr_data;
		logic                  re;
		logic [SLOT_BITS-1:0]  rd_addr;
	} tram_req_t;

endpackage

### rtl/asw_timer_ram.sv
module asw_timer_ram (
	input  logic                            clk,
	input  asw_pkg::tram_req_t              req,
	output logic [asw_pkg::TIMER_BITS-1:0] rd_data
);
	import asw_pkg::*;

	logic [TIMER_BITS-1:0] mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.re) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### rtl/asw_window_ctrl.sv
module asw_window_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  asw_pkg::item_t                  cmd,
	input  asw_pkg::cfg_t                   cfg,
	output logic                            busy,
	output logic                            res_fire,
	output asw_pkg::result_t                res_data,
	output asw_pkg::tram_req_t              tram_req,
	input  logic [asw_pkg::TIMER_BITS-1:0] tram_rdata
);
	import asw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                state_q;
	item_t                 cmd_q;
	logic [SEQ_BITS-1:0]   base_q;
	logic [SEQ_BITS-1:0]   next_q;
	logic [MAX_WINDOW-1:0] acked_q;
	logic [TIMER_BITS-1:0] wtimer_q;
	logic                  running_q;
	logic [MISS_BITS-1:0]  misses_q;
	logic [MAX_WINDOW-1:0] mask_q;
	logic [CNT_BITS-1:0]   rd_cnt_q;
	logic                  valid_s1;
	logic [SLOT_BITS-1:0]  idx_s1;

	logic                  accept;
	logic [SEQ_BITS-1:0]   seq_span;
	logic [CNT_BITS-1:0]   n;
	logic [CNT_BITS-1:0]   eff_win;
	logic [TIMER_BITS-1:0] reload;
	logic [MISS_BITS-1:0]  misses_inc;
	logic [SLOT_BITS-1:0]  base_slot;
	logic                  can_send;
	logic [SEQ_BITS-1:0]   off;
	logic                  in_win;
	logic [SLOT_BITS-1:0]  ack_slot;
	logic [MAX_WINDOW-1:0] marked;
	logic [CNT_BITS-1:0]   lead;
	logic                  lead_stop;
	logic [CNT_BITS-1:0]   gbn_left;
	logic [MAX_WINDOW-1:0] gbn_mask;
	logic [SLOT_BITS-1:0]  emit_pos;
	logic                  emit_found;
	logic [MAX_WINDOW-1:0] emit_rest;
	logic [SLOT_BITS-1:0]  s1_phys;
	logic                  s1_live;
	logic                  s1_expired;
	logic                  scan_done;
	state_t                exec_next_st;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign seq_span   = next_q - base_q;
	assign n          = (seq_span > SEQ_BITS'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW) : CNT_BITS'(seq_span);
	assign reload     = (cfg.timeout_ticks == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg.timeout_ticks);
	assign misses_inc = (misses_q == '1) ? misses_q : misses_q + MISS_BITS'(1);
	assign base_slot  = base_q[SLOT_BITS-1:0];
	assign can_send   = (n < eff_win);
	assign off        = cmd_q.ack_number - base_q;
	assign in_win     = cmd_q.ack_valid && (off < SEQ_BITS'(n));
	assign ack_slot   = cmd_q.ack_number[SLOT_BITS-1:0];
	assign gbn_left   = n - CNT_BITS'(off) - CNT_BITS'(1);
	assign s1_phys    = base_slot + idx_s1;
	assign s1_live    = valid_s1 && !acked_q[s1_phys];
	assign s1_expired = (tram_rdata <= TIMER_BITS'(1));
	assign scan_done  = (rd_cnt_q == n) && !valid_s1;

	always_comb begin
		if (cfg.window_size == '0) begin
			eff_win = CNT_BITS'(1);
		end else if (cfg.window_size > 4'(MAX_WINDOW)) begin
			eff_win = CNT_BITS'(MAX_WINDOW);
		end else begin
			eff_win = CNT_BITS'(cfg.window_size);
		end
	end

	always_comb begin
		exec_next_st = ST_IDLE;
		if (cmd_q.operation == OP_TICK) begin
			if (!cfg.arq_mode) begin
				if ((n != '0) && running_q && (wtimer_q <= TIMER_BITS'(1))) begin
					exec_next_st = ST_EMIT;
				end
			end else if (n != '0) begin
				exec_next_st = ST_SCAN;
			end
		end
	end

	always_comb begin
		marked           = acked_q;
		marked[ack_slot] = 1'b1;
		lead             = '0;
		lead_stop        = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (!lead_stop) begin
				if ((CNT_BITS'(i) < n) && marked[base_slot + SLOT_BITS'(i)]) begin
					lead = lead + CNT_BITS'(1);
				end else begin
					lead_stop = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			gbn_mask[i] = (CNT_BITS'(i) < n);
		end
	end

	always_comb begin
		emit_pos   = '0;
		emit_found = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (!emit_found && mask_q[i]) begin
				emit_pos   = SLOT_BITS'(i);
				emit_found = 1'b1;
			end
		end
		emit_rest           = mask_q;
		emit_rest[emit_pos] = 1'b0;
	end

	always_comb begin
		tram_req = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q.operation == OP_SEND && can_send) begin
					tram_req.we      = 1'b1;
					tram_req.wr_addr = next_q[SLOT_BITS-1:0];
					tram_req.wr_data = reload;
				end
			end
			ST_SCAN: begin
				tram_req.re      = (rd_cnt_q < n);
				tram_req.rd_addr = base_slot + rd_cnt_q[SLOT_BITS-1:0];
				if (s1_live) begin
					tram_req.we      = 1'b1;
					tram_req.wr_addr = s1_phys;
					tram_req.wr_data = s1_expired ? reload : tram_rdata - TIMER_BITS'(1);
				end
			end
			ST_IDLE, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_fire             = 1'b0;
		res_data.reply_kind  = KIND_RETX;
		res_data.seq_number  = base_q + SEQ_BITS'(emit_pos);
		res_data.accepted    = 1'b0;
		res_data.window_base = base_q;
		res_data.in_flight   = 4'(n);
		res_data.miss_count  = misses_q;
		res_data.last        = (emit_rest == '0);
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q.operation == OP_SEND) begin
					res_fire             = 1'b1;
					res_data.reply_kind  = KIND_SEND;
					res_data.seq_number  = next_q;
					res_data.accepted    = can_send;
					res_data.in_flight   = 4'(can_send ? n + CNT_BITS'(1) : n);
					res_data.last        = 1'b1;
				end else if (cmd_q.operation == OP_ACK) begin
					res_fire             = 1'b1;
					res_data.reply_kind  = KIND_ACK;
					res_data.seq_number  = cmd_q.ack_number;
					res_data.accepted    = in_win;
					res_data.last        = 1'b1;
					if (in_win) begin
						if (!cfg.arq_mode) begin
							res_data.window_base = cmd_q.ack_number + SEQ_BITS'(1);
							res_data.in_flight   = 4'(gbn_left);
						end else begin
							res_data.window_base = base_q + SEQ_BITS'(lead);
							res_data.in_flight   = 4'(n - lead);
						end
					end
				end
			end
			ST_EMIT: begin
				res_fire = 1'b1;
			end
			ST_IDLE, ST_SCAN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		idx_s1 <= rd_cnt_q[SLOT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			next_q    <= '0;
			acked_q   <= '0;
			wtimer_q  <= '0;
			running_q <= 1'b0;
			misses_q  <= '0;
			mask_q    <= '0;
			rd_cnt_q  <= '0;
			valid_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= exec_next_st;
					case (cmd_q.operation)
						OP_SEND: begin
							if (can_send) begin
								acked_q[next_q[SLOT_BITS-1:0]] <= 1'b0;
								next_q <= next_q + SEQ_BITS'(1);
								if (n == '0) begin
									running_q <= 1'b1;
									wtimer_q  <= reload;
								end
							end
						end
						OP_ACK: begin
							if (in_win) begin
								if (!cfg.arq_mode) begin
									base_q <= cmd_q.ack_number + SEQ_BITS'(1);
									if (gbn_left == '0) begin
										running_q <= 1'b0;
									end else begin
										wtimer_q <= reload;
									end
								end else begin
									acked_q   <= marked;
									base_q    <= base_q + SEQ_BITS'(lead);
									running_q <= (n != lead);
								end
							end
						end
						OP_TICK: begin
							if (!cfg.arq_mode) begin
								if (n == '0) begin
									running_q <= 1'b0;
								end else if (running_q) begin
									if (wtimer_q <= TIMER_BITS'(1)) begin
										misses_q <= misses_inc;
										wtimer_q <= reload;
										mask_q   <= gbn_mask;
									end else begin
										wtimer_q <= wtimer_q - TIMER_BITS'(1);
									end
								end
							end else if (n != '0) begin
								rd_cnt_q <= '0;
								valid_s1 <= 1'b0;
								mask_q   <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					valid_s1 <= (rd_cnt_q < n);
					if (rd_cnt_q < n) begin
						rd_cnt_q <= rd_cnt_q + CNT_BITS'(1);
					end
					if (s1_live && s1_expired) begin
						misses_q        <= misses_inc;
						mask_q[idx_s1]  <= 1'b1;
					end
					if (scan_done) begin
						state_q <= (mask_q != '0) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					mask_q <= emit_rest;
					if (emit_rest == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/arq_sender_window_core.sv
// channel   direction  handshake                 payload
// command   in         start high, busy low      cmd   (operation, ack_number, ack_valid)
// result    out        res_strobe, one cycle     res   (reply_kind .. last)
// config    in         cfg_we                    cfg_idx, cfg_wdata
//
// A send or an ack is captured, then does one read-modify-write of the slot state;
// its single result follows on the next cycle. A go-back-N expiry then gives one retransmit
// order per in-flight packet. A selective-repeat tick walks the slot timer memory one slot
// at a time, then gives one retransmit order per expired unacked slot.
// Reset clears the window, timers and miss count; the timer memory needs no clearing pass.
// Results cannot be stalled: each is shown for exactly one cycle.
module arq_sender_window_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  asw_pkg::item_t                      cmd,
	output logic                                res_strobe,
	output asw_pkg::result_t                    res,
	input  logic                                cfg_we,
	input  logic [asw_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [asw_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import asw_pkg::*;

	cfg_t                  cfg_q;
	tram_req_t             tram_req;
	logic [TIMER_BITS-1:0] tram_rdata;
	logic                  res_fire;
	result_t               res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arq_mode      <= 1'b0;
			cfg_q.window_size   <= 4'd8;
			cfg_q.timeout_ticks <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:    cfg_q.arq_mode      <= cfg_wdata[0];
				REG_WINDOW:  cfg_q.window_size   <= cfg_wdata[3:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe <= 1'b0;
		end else begin
			res_strobe <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			res <= res_data;
		end
	end

	asw_timer_ram u_ram (
		.clk     (clk),
		.req     (tram_req),
		.rd_data (tram_rdata)
	);

	asw_window_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.busy       (busy),
		.res_fire   (res_fire),
		.res_data   (res_data),
		.tram_req   (tram_req),
		.tram_rdata (tram_rdata)
	);

endmodule

### rtl/asw_checker.sv
module asw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                res_strobe,
	input asw_pkg::result_t                    res
);
	import asw_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !res.last |=> res_strobe)
		else $error("retransmit burst broken before last");

	a_single_reply: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && (res.reply_kind == KIND_SEND || res.reply_kind == KIND_ACK) |-> res.last)
		else $error("send or ack reply not marked last");

	a_retx_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.reply_kind == KIND_RETX |-> !res.accepted)
		else $error("retransmit order flagged accepted");

	a_in_flight_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> res.in_flight <= 4'(MAX_WINDOW))
		else $error("in_flight beyond window capacity");

endmodule

bind arq_sender_window_core asw_checker u_asw_checker (.*);

### tb/sv/arq_sender_window_core_test.sv
module arq_sender_window_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import asw_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int RAND_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 23;
	localparam int PRINT_CAP = 40;

	typedef struct {
		item_t it;
		bit    rel;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t cmd = '0;
	logic res_strobe;
	result_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	arq_sender_window_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.res_strobe(res_strobe),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	logic        mode_q;
	logic [3:0]  wsize_q;
	logic [15:0] tout_q;
	logic [15:0] base_q;
	logic [15:0] next_q;
	logic        acked_q [MAX_WINDOW];
	logic [15:0] stimer_q [MAX_WINDOW];
	logic [15:0] wtimer_q;
	logic        running_q;
	logic [31:0] misses_q;

	result_t replies_due[$];
	pend_t   pending[$];
	bit      taken = 1'b0;
	bit      calm = 1'b0;
	int      gap_left = 0;
	int      fault_count = 0;

	task automatic clear_window();
		mode_q = 1'b0;
		wsize_q = 4'd8;
		tout_q = 16'd1000;
		base_q = '0;
		next_q = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			acked_q[i] = 1'b0;
			stimer_q[i] = '0;
		end
		wtimer_q = '0;
		running_q = 1'b0;
		misses_q = '0;
	endtask

	function automatic int window_limit();
		int w;
		w = wsize_q;
		if (w < 1) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	function automatic logic [15:0] reload_ticks();
		return (tout_q == 16'd0) ? 16'd1 : tout_q;
	endfunction

	function automatic int in_flight_now();
		logic [15:0] d;
		d = next_q - base_q;
		return (d > MAX_WINDOW) ? MAX_WINDOW : int'(d);
	endfunction

	task automatic slide_window(input int k);
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (i + k < MAX_WINDOW) begin
				acked_q[i] = acked_q[i + k];
				stimer_q[i] = stimer_q[i + k];
			end else begin
				acked_q[i] = 1'b0;
				stimer_q[i] = '0;
			end
		end
		base_q = base_q + 16'(k);
	endtask

	task automatic count_miss();
		if (misses_q != '1) misses_q++;
	endtask

	function automatic result_t shape_reply(logic [1:0] kind, logic [15:0] seq, logic acc);
		result_t r;
		r.reply_kind = kind;
		r.seq_number = seq;
		r.accepted = acc;
		r.window_base = base_q;
		r.in_flight = 4'(in_flight_now());
		r.miss_count = misses_q;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic advance_window(input item_t it);
		int n;
		int k;
		logic [15:0] off;
		logic [15:0] seq;
		logic acc;
		logic [15:0] resend[$];
		result_t r;
		n = in_flight_now();
		acc = 1'b0;
		case (it.operation)
			OP_SEND: begin
				seq = next_q;
				if (n < window_limit()) begin
					acked_q[n] = 1'b0;
					stimer_q[n] = reload_ticks();
					if (n == 0) begin
						running_q = 1'b1;
						wtimer_q = reload_ticks();
					end
					next_q = next_q + 16'd1;
					acc = 1'b1;
				end
				r = shape_reply(KIND_SEND, seq, acc);
				r.last = 1'b1;
				replies_due.insert(replies_due.size(), r);
			end
			OP_ACK: begin
				if (it.ack_valid) begin
					off = it.ack_number - base_q;
					if (int'(off) < n) begin
						acc = 1'b1;
						if (!mode_q) begin
							slide_window(int'(off) + 1);
							if (in_flight_now() == 0) running_q = 1'b0;
							else wtimer_q = reload_ticks();
						end else begin
							acked_q[off] = 1'b1;
							k = 0;
							while (k < n && acked_q[k]) k++;
							slide_window(k);
							running_q = (in_flight_now() != 0);
						end
					end
				end
				r = shape_reply(KIND_ACK, it.ack_number, acc);
				r.last = 1'b1;
				replies_due.insert(replies_due.size(), r);
			end
			OP_TICK: begin
				if (!mode_q) begin
					if (n == 0) begin
						running_q = 1'b0;
					end else if (running_q) begin
						if (wtimer_q <= 16'd1) begin
							count_miss();
							wtimer_q = reload_ticks();
							for (int i = 0; i < n; i++) resend.insert(resend.size(), base_q + 16'(i));
						end else begin
							wtimer_q--;
						end
					end
				end else begin
					for (int i = 0; i < n; i++) begin
						if (!acked_q[i]) begin
							if (stimer_q[i] <= 16'd1) begin
								count_miss();
								stimer_q[i] = reload_ticks();
								resend.insert(resend.size(), base_q + 16'(i));
							end else begin
								stimer_q[i]--;
							end
						end
					end
				end
				for (int i = 0; i < resend.size(); i++) begin
					r = shape_reply(KIND_RETX, resend[i], 1'b0);
					r.last = (i == resend.size() - 1);
					replies_due.insert(replies_due.size(), r);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		if (fault_count < PRINT_CAP) $display("ERROR %0t ns: %s", $realtime, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(negedge clk) begin : drive_cmd
		pend_t p;
		item_t nxt;
		logic go;
		nxt = cmd;
		go = start;
		if (!(start && !taken)) begin
			go = 1'b0;
			taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (arst_n && pending.size() > 0) begin
				if (!calm && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 13) - 1;
				end else begin
					p = pending[0];
					pending.delete(0);
					nxt = p.it;
					if (p.rel) nxt.ack_number = base_q + p.it.ack_number;
					go = 1'b1;
				end
			end
		end
		start <= go;
		cmd <= nxt;
	end

	always @(posedge clk) begin : observe
		result_t want;
		if (arst_n) begin
			if (res_strobe) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result seq %0h", res.seq_number));
				end else begin
					want = replies_due[0];
					replies_due.delete(0);
					check_field("reply_kind", 32'(res.reply_kind), 32'(want.reply_kind));
					check_field("seq_number", 32'(res.seq_number), 32'(want.seq_number));
					check_field("accepted", 32'(res.accepted), 32'(want.accepted));
					check_field("window_base", 32'(res.window_base), 32'(want.window_base));
					check_field("in_flight", 32'(res.in_flight), 32'(want.in_flight));
					check_field("miss_count", res.miss_count, want.miss_count);
					check_field("last", 32'(res.last), 32'(want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODE: mode_q = cfg_wdata[0];
					REG_WINDOW: wsize_q = cfg_wdata[3:0];
					REG_TIMEOUT: tout_q = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy) begin
				advance_window(cmd);
				taken = 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
	endtask

	task automatic set_window(input logic mode, input logic [3:0] wsize,
			input logic [15:0] ticks);
		write_reg(REG_MODE, {15'($urandom), mode});
		write_reg(REG_WINDOW, {12'($urandom), wsize});
		write_reg(REG_TIMEOUT, ticks);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(input logic [1:0] op, input logic [15:0] ackn, input logic av);
		pend_t p;
		p.it.operation = op;
		p.it.ack_number = ackn;
		p.it.ack_valid = av;
		p.rel = 1'b0;
		pending.insert(pending.size(), p);
	endtask

	function automatic pend_t random_item();
		pend_t p;
		int pick;
		pick = $urandom_range(0, 99);
		p.rel = 1'b0;
		p.it.ack_number = 16'($urandom);
		p.it.ack_valid = 1'($urandom);
		if (pick < 35) begin
			p.it.operation = OP_SEND;
		end else if (pick < 65) begin
			p.it.operation = OP_ACK;
			p.it.ack_valid = 1'b1;
			p.it.ack_number = 16'($urandom_range(0, MAX_WINDOW));
			p.rel = 1'b1;
		end else if (pick < 93) begin
			p.it.operation = OP_TICK;
		end else if (pick < 97) begin
			p.it.operation = OP_ACK;
		end else begin
			p.it.operation = OP_UNUSED;
		end
		return p;
	endfunction

	task automatic drain();
		while (pending.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		logic [3:0]  wsize;
		logic [15:0] ticks;
		clear_window();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_UNUSED, 16'($urandom));
		set_window(1'b0, 4'd0, 16'd0);
		queue_item(OP_ACK, 16'hFFFF, 1'b0);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		queue_item(OP_UNUSED, 16'hFFFF, 1'b1);
		queue_item(OP_SEND, 16'h0000, 1'b0);
		queue_item(OP_SEND, 16'hFFFF, 1'b1);
		queue_item(OP_ACK, 16'hFFFF, 1'b1);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		queue_item(OP_ACK, 16'h0000, 1'b1);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		drain();

		set_window(1'b1, 4'd15, 16'd2);
		repeat (9) queue_item(OP_SEND, 16'($urandom), 1'($urandom));
		queue_item(OP_ACK, 16'd3, 1'b1);
		queue_item(OP_ACK, 16'd3, 1'b1);
		queue_item(OP_ACK, 16'd0, 1'b1);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		drain();

		set_window(1'b0, 4'd2, 16'd3);
		queue_item(OP_SEND, 16'h0000, 1'b0);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		queue_item(OP_TICK, 16'h0000, 1'b0);
		queue_item(OP_ACK, 16'd4, 1'b1);
		drain();

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			calm = (phase >= RAND_PHASES - 2);
			wsize = 4'($urandom_range(0, 15));
			ticks = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
			if (phase == 0) set_window(1'b0, 4'd1, 16'hFFFF);
			else if (phase == 1) set_window(1'b1, 4'd8, 16'd1);
			else set_window(1'($urandom), wsize, ticks);
			repeat (ITEMS_PER_PHASE) pending.insert(pending.size(), random_item());
			drain();
		end

		if (fault_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#400us;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
